/* rtl/tlpm_pkg.sv */
`default_nettype none
package tlpm_pkg;

   localparam int OFFSET_WIDTH          = 12;
   localparam int PAGE_INDEX_WIDTH      = 8;
   localparam int DIRECTORY_INDEX_WIDTH = 4;
   localparam int CLIENT_COUNT          = 16;

   localparam int ADDR_W   = 32;
   localparam int CID_W    = 4;
   localparam int REGION_W = 25;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 24;
   localparam int ENTRY_W  = CID_W + 1;

   localparam int TOTAL_W     = DIRECTORY_INDEX_WIDTH + PAGE_INDEX_WIDTH;
   localparam int TOTAL_PAGES = 1 << TOTAL_W;
   localparam int DIR_COUNT   = 1 << DIRECTORY_INDEX_WIDTH;
   localparam int CLIENT_IDX_W = $clog2(CLIENT_COUNT);

   localparam int SPAN_W     = OFFSET_WIDTH + TOTAL_W;
   localparam int ADDR_EXT_W = (SPAN_W > ADDR_W) ? SPAN_W : ADDR_W;

   localparam int ALU_W = REGION_W + 1;
   localparam int CNT_W = ALU_W - OFFSET_WIDTH;

   localparam logic [ALU_W-1:0] PAGE_ROUND = ALU_W'((64'd1 << OFFSET_WIDTH) - 64'd1);

   localparam int REQ_DATA_W = ((ADDR_W + CID_W + REGION_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CID_W + INDEX_W + 7) / 8) * 8;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_DIR  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERRUN = 2'd3;

   localparam logic FUNC_MAP       = 1'b0;
   localparam logic FUNC_TRANSLATE = 1'b1;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             cin;
   } alu_op_type;

endpackage
`default_nettype wire

/* rtl/two_level_page_map_translate_core.sv */
`default_nettype none
// channel | direction | tdata (low bit up)                          | tuser
// req     | in        | address[31:0], client_id[35:32],            | func
//         |           | region_bytes[60:36], zero fill to 64        |
// rsp     | out       | mapped_client[3:0], client_index[27:4],     | status
//         |           | zero fill to 32                             |
// After reset the page table is cleared one entry a cycle, all 2^12 = 4096 entries,
// with req_tready low. A translate reads the page table RAM into a register, then
// does one subtract in the shared adder and registers the result. A zero size or
// ignored map answers straight from idle; a map rounds the size up to pages in the
// shared adder, then does one page table write per cycle. One transaction in flight;
// rsp is a register, so req_tready returns once no result is held or it is being taken.
module two_level_page_map_translate_core (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [tlpm_pkg::REQ_DATA_W-1:0]    req_tdata,  // address, client_id, region_bytes
   input  wire                                req_tuser,  // func
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [tlpm_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // mapped_client, client_index
   output logic [tlpm_pkg::STATUS_W-1:0]      rsp_tuser   // status
);

   localparam logic [2:0] S_CLEAR     = 3'd0;
   localparam logic [2:0] S_IDLE      = 3'd1;
   localparam logic [2:0] S_TRANS     = 3'd2;
   localparam logic [2:0] S_MAP_SETUP = 3'd3;
   localparam logic [2:0] S_MAP_RUN   = 3'd4;

   localparam int TW = tlpm_pkg::TOTAL_W;
   localparam int OW = tlpm_pkg::OFFSET_WIDTH;
   localparam int AW = tlpm_pkg::ALU_W;

   logic [2:0] state_ff, state_in;
   logic [TW-1:0] clr_ff, clr_in;
   logic [TW-1:0] page_ff, page_in;
   logic [OW-1:0] offset_ff, offset_in;
   logic [tlpm_pkg::CID_W-1:0] cid_ff, cid_in;
   logic [tlpm_pkg::REGION_W-1:0] bytes_ff, bytes_in;
   logic [TW:0] p_ff, p_in;
   logic [tlpm_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [tlpm_pkg::DIR_COUNT-1:0] dir_ff, dir_in;
   logic [TW-1:0] base_ff [tlpm_pkg::CLIENT_COUNT];
   logic base_we;
   logic rsp_valid_ff, rsp_valid_in;
   logic [tlpm_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [tlpm_pkg::CID_W-1:0] rsp_client_ff, rsp_client_in;
   logic [tlpm_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   logic [tlpm_pkg::ADDR_W-1:0] req_address;
   logic [tlpm_pkg::CID_W-1:0] req_cid;
   logic [tlpm_pkg::REGION_W-1:0] req_bytes;
   logic [tlpm_pkg::ADDR_EXT_W-1:0] addr_ext;
   logic [TW-1:0] req_page;
   logic accept;

   logic ram_we, ram_re;
   logic [TW-1:0] ram_waddr;
   logic [tlpm_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

   tlpm_pkg::alu_op_type alu_op;
   logic [AW-1:0] alu_sum;

   logic [tlpm_pkg::CID_W-1:0] owner;
   logic [TW-1:0] owner_base;
   logic [tlpm_pkg::INDEX_W-1:0] rel;

   assign req_address = req_tdata[tlpm_pkg::ADDR_W-1:0];
   assign req_cid = req_tdata[tlpm_pkg::ADDR_W +: tlpm_pkg::CID_W];
   assign req_bytes = req_tdata[tlpm_pkg::ADDR_W + tlpm_pkg::CID_W +: tlpm_pkg::REGION_W];
   assign addr_ext = tlpm_pkg::ADDR_EXT_W'(req_address);
   assign req_page = addr_ext[OW +: TW];

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_status_ff;
   assign rsp_tdata = tlpm_pkg::RSP_DATA_W'({rsp_index_ff, rsp_client_ff});

   assign owner = ram_rdata[tlpm_pkg::CID_W-1:0];
   assign owner_base = base_ff[tlpm_pkg::CLIENT_IDX_W'(owner)];
   assign rel = alu_sum[tlpm_pkg::INDEX_W-1:0];

   tlpm_ram #(
      .WIDTH(tlpm_pkg::ENTRY_W),
      .DEPTH(tlpm_pkg::TOTAL_PAGES)
   ) u_page_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(req_page),
      .rd_data(ram_rdata)
   );

   tlpm_alu u_alu (
      .op (alu_op),
      .sum(alu_sum)
   );

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      page_in = page_ff;
      offset_in = offset_ff;
      cid_in = cid_ff;
      bytes_in = bytes_ff;
      p_in = p_ff;
      cnt_in = cnt_ff;
      dir_in = dir_ff;
      base_we = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_client_in = rsp_client_ff;
      rsp_index_in = rsp_index_ff;
      ram_we = 1'b0;
      ram_re = 1'b0;
      ram_waddr = p_ff[TW-1:0];
      ram_wdata = {1'b1, cid_ff};
      alu_op.a = AW'(p_ff);
      alu_op.b = '0;
      alu_op.cin = 1'b1;

      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == {TW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               page_in = req_page;
               offset_in = addr_ext[OW-1:0];
               cid_in = req_cid;
               bytes_in = req_bytes;
               p_in = {1'b0, req_page};
               if (req_tuser == tlpm_pkg::FUNC_TRANSLATE) begin
                  ram_re = 1'b1;
                  state_in = S_TRANS;
               end else if (req_bytes == '0 || int'(req_cid) >= tlpm_pkg::CLIENT_COUNT) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = tlpm_pkg::ST_OK;
                  rsp_client_in = '0;
                  rsp_index_in = '0;
               end else begin
                  state_in = S_MAP_SETUP;
               end
            end
         end
         S_TRANS: begin
            alu_op.a = AW'(page_ff);
            alu_op.b = ~AW'(owner_base);
            alu_op.cin = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_client_in = '0;
            rsp_index_in = '0;
            if (!dir_ff[page_ff[TW-1 -: tlpm_pkg::DIRECTORY_INDEX_WIDTH]]) begin
               rsp_status_in = tlpm_pkg::ST_NO_DIR;
            end else if (!ram_rdata[tlpm_pkg::ENTRY_W-1] ||
                         int'(owner) >= tlpm_pkg::CLIENT_COUNT) begin
               rsp_status_in = tlpm_pkg::ST_UNMAPPED;
            end else begin
               rsp_status_in = tlpm_pkg::ST_OK;
               rsp_client_in = owner;
               rsp_index_in = tlpm_pkg::INDEX_W'(rel << OW) + tlpm_pkg::INDEX_W'(offset_ff);
            end
            state_in = S_IDLE;
         end
         S_MAP_SETUP: begin
            alu_op.a = AW'(bytes_ff);
            alu_op.b = tlpm_pkg::PAGE_ROUND;
            alu_op.cin = 1'b0;
            cnt_in = alu_sum[AW-1:OW];
            base_we = 1'b1;
            state_in = S_MAP_RUN;
         end
         S_MAP_RUN: begin
            if (cnt_ff == '0 || p_ff[TW]) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = (cnt_ff == '0) ? tlpm_pkg::ST_OK : tlpm_pkg::ST_OVERRUN;
               rsp_client_in = '0;
               rsp_index_in = '0;
               state_in = S_IDLE;
            end else begin
               ram_we = 1'b1;
               dir_in[p_ff[TW-1 -: tlpm_pkg::DIRECTORY_INDEX_WIDTH]] = 1'b1;
               cnt_in = cnt_ff - 1'b1;
               p_in = alu_sum[TW:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         dir_ff <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff <= '{default: '0};
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         dir_ff <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
         if (base_we) begin
            base_ff[tlpm_pkg::CLIENT_IDX_W'(cid_ff)] <= page_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      offset_ff <= offset_in;
      cid_ff <= cid_in;
      bytes_ff <= bytes_in;
      p_ff <= p_in;
      cnt_ff <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_client_ff <= rsp_client_in;
      rsp_index_ff <= rsp_index_in;
   end

endmodule
`default_nettype wire

/* rtl/tlpm_ram.sv */
`default_nettype none
module tlpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* rtl/tlpm_alu.sv */
`default_nettype none
module tlpm_alu (
   input  wire  tlpm_pkg::alu_op_type     op,
   output logic [tlpm_pkg::ALU_W-1:0]     sum
);

   assign sum = op.a + op.b + tlpm_pkg::ALU_W'(op.cin);

endmodule
`default_nettype wire
